FILE: design/fcs_pkg.sv
`timescale 1ns / 1ps

package fcs_pkg;

    // default sizes
    localparam int NUM_CATALOGS_DEF  = 4;
    localparam int CATALOG_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF   = 32;

    // configuration register
    localparam int COUNT_W    = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 1;
    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_ACTIVE = 1'b0;

    // command / front-back queue
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_UNBUILT = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;
    localparam logic [2:0] ST_ORDER   = 3'd5;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_REJECT = 3'd4;

    // classified item: what the back end has to do
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] status;
    } cls_t;

endpackage

FILE: design/fractional_cascade_search.sv
`timescale 1ns / 1ps
// clear, rejects: dispatch then output register; append adds an order check on the last entry
// build: per layer, last catalog first: merge with every second next-layer entry, then lower bounds
// query: binary search of the first layer, then per catalog a walk, bridge read and match check
// occupancy: one item in the back end at a time, set by the single sequencer and
// its registered memory reads; a two-entry queue decouples input acceptance
// reset: rst_n async active low clears lengths, built flag, the count register and queue

module fractional_cascade_search #(
    parameter int NUM_CATALOGS  = fcs_pkg::NUM_CATALOGS_DEF,
    parameter int CATALOG_DEPTH = fcs_pkg::CATALOG_DEPTH_DEF,
    parameter int VALUE_WIDTH   = fcs_pkg::VALUE_WIDTH_DEF,
    localparam int CW = (NUM_CATALOGS > 1) ? $clog2(NUM_CATALOGS) : 1,
    localparam int LW = $clog2(CATALOG_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fcs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fcs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fcs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // item in
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      command,
    input  logic [CW-1:0]                   catalog_index,
    input  logic [VALUE_WIDTH-1:0]          value,
    // item out
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [CW-1:0]                   result_catalog,
    output logic [LW-1:0]                   position,
    output logic                            found,
    output logic                            last
);

    localparam int QW = $bits(fcs_pkg::cls_t) + CW + VALUE_WIDTH;

    logic [fcs_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [fcs_pkg::COUNT_W-1:0] count_m1;
    logic                        cfg_wr;
    logic [CW-1:0]               last_idx;

    fcs_pkg::cls_t               f_cls, q_cls;
    logic [CW-1:0]               f_catalog, q_catalog;
    logic [VALUE_WIDTH-1:0]      f_key, q_key;
    logic [QW-1:0]               q_head;
    logic                        q_full, q_valid, q_pop;

    // register write completes in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == fcs_pkg::ADDR_NUM_ACTIVE);
    assign prdata = (paddr == fcs_pkg::ADDR_NUM_ACTIVE) ?
                    {{(fcs_pkg::APB_DATA_W - fcs_pkg::COUNT_W){1'b0}}, count_reg} : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
        begin
            count_next = pwdata[fcs_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // index of the final catalog; only used once the count has been checked
    assign count_m1 = count_reg - 1'b1;
    assign last_idx = CW'(count_m1);

    // front end: classify the command against the configuration
    fcs_front #(
        .NUM_CATALOGS (NUM_CATALOGS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_front (
        .command       (command),
        .catalog_index (catalog_index),
        .value         (value),
        .active_count  (count_reg),
        .cls           (f_cls),
        .cls_catalog   (f_catalog),
        .cls_key       (f_key)
    );

    // short queue between classification and execution
    fcs_queue #(
        .WIDTH (QW),
        .DEPTH (fcs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data ({f_cls, f_catalog, f_key}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign in_stall = q_full;
    assign {q_cls, q_catalog, q_key} = q_head;

    // back end: build and query sequencer with the catalog and layer memories
    fcs_back #(
        .NUM_CATALOGS  (NUM_CATALOGS),
        .CATALOG_DEPTH (CATALOG_DEPTH),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cls          (q_cls),
        .q_catalog      (q_catalog),
        .q_key          (q_key),
        .q_pop          (q_pop),
        .cfg_wr         (cfg_wr),
        .last_idx       (last_idx),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .result_catalog (result_catalog),
        .position       (position),
        .found          (found),
        .last           (last)
    );

endmodule

FILE: design/fcs_front.sv
`timescale 1ns / 1ps

module fcs_front #(
    parameter int NUM_CATALOGS = fcs_pkg::NUM_CATALOGS_DEF,
    parameter int VALUE_WIDTH  = fcs_pkg::VALUE_WIDTH_DEF,
    localparam int CW = (NUM_CATALOGS > 1) ? $clog2(NUM_CATALOGS) : 1
) (
    input  logic [1:0]                 command,
    input  logic [CW-1:0]              catalog_index,
    input  logic [VALUE_WIDTH-1:0]     value,
    input  logic [fcs_pkg::COUNT_W-1:0] active_count,
    output fcs_pkg::cls_t              cls,
    output logic [CW-1:0]              cls_catalog,
    output logic [VALUE_WIDTH-1:0]     cls_key
);

    logic count_bad;
    logic count_zero;

    // offset binary, so unsigned compare gives signed order
    assign cls_key = value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    assign count_zero = (active_count == '0);
    assign count_bad  = (active_count > NUM_CATALOGS);

    always_comb
    begin
        cls.op      = fcs_pkg::OP_CLEAR;
        cls.status  = fcs_pkg::ST_OK;
        cls_catalog = '0;
        case (command)
            fcs_pkg::CMD_CLEAR:
            begin
                cls.op = fcs_pkg::OP_CLEAR;
            end
            fcs_pkg::CMD_APPEND:
            begin
                cls_catalog = catalog_index;
                if ((catalog_index >= active_count) || (catalog_index >= NUM_CATALOGS))
                begin
                    cls.op     = fcs_pkg::OP_REJECT;
                    cls.status = fcs_pkg::ST_RANGE;
                end
                else
                begin
                    cls.op = fcs_pkg::OP_APPEND;
                end
            end
            default:
            begin
                if (count_zero)
                begin
                    cls.op     = fcs_pkg::OP_REJECT;
                    cls.status = fcs_pkg::ST_NONE;
                end
                else if (count_bad)
                begin
                    cls.op     = fcs_pkg::OP_REJECT;
                    cls.status = fcs_pkg::ST_RANGE;
                end
                else if (command == fcs_pkg::CMD_BUILD)
                begin
                    cls.op = fcs_pkg::OP_BUILD;
                end
                else
                begin
                    cls.op = fcs_pkg::OP_QUERY;
                end
            end
        endcase
    end

endmodule

FILE: design/fcs_queue.sv
`timescale 1ns / 1ps

module fcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fcs_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == NW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/fcs_back.sv
`timescale 1ns / 1ps

module fcs_back #(
    parameter int NUM_CATALOGS  = fcs_pkg::NUM_CATALOGS_DEF,
    parameter int CATALOG_DEPTH = fcs_pkg::CATALOG_DEPTH_DEF,
    parameter int VALUE_WIDTH   = fcs_pkg::VALUE_WIDTH_DEF,
    localparam int CW  = (NUM_CATALOGS > 1) ? $clog2(NUM_CATALOGS) : 1,
    localparam int NCP = 1 << CW,
    localparam int SW  = $clog2(CATALOG_DEPTH),
    localparam int LW  = $clog2(CATALOG_DEPTH + 1),
    localparam int YW  = SW + 1,
    localparam int YLW = $clog2(2 * CATALOG_DEPTH + 1),
    localparam int PMW = LW + YLW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  fcs_pkg::cls_t          q_cls,
    input  logic [CW-1:0]          q_catalog,
    input  logic [VALUE_WIDTH-1:0] q_key,
    output logic                   q_pop,
    input  logic                   cfg_wr,
    input  logic [CW-1:0]          last_idx,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [2:0]             status,
    output logic [CW-1:0]          result_catalog,
    output logic [LW-1:0]          position,
    output logic                   found,
    output logic                   last
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_A_USE  = 5'd2;
    localparam logic [4:0] S_M_RD   = 5'd3;
    localparam logic [4:0] S_M_USE  = 5'd4;
    localparam logic [4:0] S_P_RD   = 5'd5;
    localparam logic [4:0] S_P_USE  = 5'd6;
    localparam logic [4:0] S_BS_RD  = 5'd7;
    localparam logic [4:0] S_BS_USE = 5'd8;
    localparam logic [4:0] S_WD_RD  = 5'd9;
    localparam logic [4:0] S_WD_USE = 5'd10;
    localparam logic [4:0] S_WU_RD  = 5'd11;
    localparam logic [4:0] S_WU_USE = 5'd12;
    localparam logic [4:0] S_C_RD   = 5'd13;
    localparam logic [4:0] S_C_USE  = 5'd14;
    localparam logic [4:0] S_F_RD   = 5'd15;
    localparam logic [4:0] S_F_USE  = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    // memories
    logic [VALUE_WIDTH-1:0] cat_mem [NCP << SW];
    logic [VALUE_WIDTH-1:0] lay_mem [NCP << YW];
    logic [PMW-1:0]         pos_mem [NCP << YW];

    logic [VALUE_WIDTH-1:0] cat_rd_reg, lay_a_rd_reg, lay_b_rd_reg;
    logic [PMW-1:0]         pos_rd_reg;
    logic [CW+SW-1:0]       cat_ra;
    logic [CW+YW-1:0]       lay_a_ra, lay_b_ra, pos_ra;
    logic                   cat_we, lay_we, pos_we;
    logic [CW+SW-1:0]       cat_wa;
    logic [CW+YW-1:0]       lay_wa, pos_wa;
    logic [VALUE_WIDTH-1:0] lay_wd;
    logic [PMW-1:0]         pos_wd;

    // control state
    logic [4:0]             state_reg, state_next;
    fcs_pkg::cls_t          cls_reg, cls_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [LW-1:0]          cat_len_reg [NCP];
    logic [LW-1:0]          cat_len_next [NCP];
    logic [YLW-1:0]         lay_len_reg [NCP];
    logic [YLW-1:0]         lay_len_next [NCP];
    logic                   built_reg, built_next;
    logic [LW-1:0]          a_reg, a_next;
    logic [YLW-1:0]         b_reg, b_next;
    logic [YLW-1:0]         o_reg, o_next;
    logic [YLW-1:0]         e_reg, e_next;
    logic [LW-1:0]          p_reg, p_next;
    logic [YLW-1:0]         q_reg, q_next;
    logic [YLW-1:0]         lo_reg, lo_next;
    logic [YLW-1:0]         hi_reg, hi_next;
    logic [YLW-1:0]         pos_reg, pos_next;
    logic [LW-1:0]          cp_reg, cp_next;
    logic [YLW-1:0]         bridge_reg, bridge_next;

    // pending result
    logic [2:0]             res_status_reg, res_status_next;
    logic [CW-1:0]          res_cat_reg, res_cat_next;
    logic [LW-1:0]          res_pos_reg, res_pos_next;
    logic                   res_found_reg, res_found_next;
    logic                   res_last_reg, res_last_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_status_reg;
    logic [CW-1:0]          out_cat_reg;
    logic [LW-1:0]          out_pos_reg;
    logic                   out_found_reg, out_last_reg;
    logic                   out_free, out_load;

    logic [CW-1:0]          idx_p1;
    logic                   has_next;
    logic [LW-1:0]          clen, clen_m1;
    logic [YLW-1:0]         lcur, nlen, mid, pos_m1;
    logic                   take_cat;

    assign idx_p1   = idx_reg + 1'b1;
    assign has_next = (idx_reg != last_idx);
    assign clen     = cat_len_reg[idx_reg];
    assign clen_m1  = clen - 1'b1;
    assign lcur     = lay_len_reg[idx_reg];
    assign nlen     = has_next ? lay_len_reg[idx_p1] : '0;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_m1   = pos_reg - 1'b1;
    assign take_cat = (a_reg < clen) && ((b_reg >= nlen) || (cat_rd_reg <= lay_b_rd_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // read addresses
    always_comb
    begin
        case (state_reg)
            S_DISP:  cat_ra = {idx_reg, clen_m1[SW-1:0]};
            S_P_RD:  cat_ra = {idx_reg, p_reg[SW-1:0]};
            S_F_RD:  cat_ra = {idx_reg, cp_reg[SW-1:0]};
            default: cat_ra = {idx_reg, a_reg[SW-1:0]};
        endcase
        case (state_reg)
            S_P_RD:  lay_a_ra = {idx_reg, e_reg[YW-1:0]};
            S_BS_RD: lay_a_ra = {idx_reg, mid[YW-1:0]};
            S_WD_RD: lay_a_ra = {idx_reg, pos_m1[YW-1:0]};
            default: lay_a_ra = {idx_reg, pos_reg[YW-1:0]};
        endcase
        case (state_reg)
            S_P_RD:  lay_b_ra = {idx_p1, q_reg[YW-1:0]};
            default: lay_b_ra = {idx_p1, b_reg[YW-1:0]};
        endcase
        pos_ra = {idx_reg, pos_reg[YW-1:0]};
    end

    always_comb
    begin
        state_next      = state_reg;
        cls_next        = cls_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        built_next      = built_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        o_next          = o_reg;
        e_next          = e_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        cp_next         = cp_reg;
        bridge_next     = bridge_reg;
        res_status_next = res_status_reg;
        res_cat_next    = res_cat_reg;
        res_pos_next    = res_pos_reg;
        res_found_next  = res_found_reg;
        res_last_next   = res_last_reg;
        for (int i = 0; i < NCP; i++)
        begin
            cat_len_next[i] = cat_len_reg[i];
            lay_len_next[i] = lay_len_reg[i];
        end
        cat_we   = 1'b0;
        cat_wa   = {idx_reg, clen[SW-1:0]};
        lay_we   = 1'b0;
        lay_wa   = {idx_reg, o_reg[YW-1:0]};
        lay_wd   = take_cat ? cat_rd_reg : lay_b_rd_reg;
        pos_we   = 1'b0;
        pos_wa   = {idx_reg, e_reg[YW-1:0]};
        pos_wd   = {p_reg, q_reg};
        out_load = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cls_next   = q_cls;
                    key_next   = q_key;
                    idx_next   = q_catalog;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_status_next = fcs_pkg::ST_OK;
                res_cat_next    = '0;
                res_pos_next    = '0;
                res_found_next  = 1'b0;
                res_last_next   = 1'b1;
                case (cls_reg.op)
                    fcs_pkg::OP_CLEAR:
                    begin
                        for (int i = 0; i < NCP; i++)
                        begin
                            cat_len_next[i] = '0;
                            lay_len_next[i] = '0;
                        end
                        built_next = 1'b0;
                        state_next = S_EMIT;
                    end
                    fcs_pkg::OP_APPEND:
                    begin
                        res_cat_next = idx_reg;
                        if (clen >= LW'(CATALOG_DEPTH))
                        begin
                            res_status_next = fcs_pkg::ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_A_USE;
                        end
                    end
                    fcs_pkg::OP_BUILD:
                    begin
                        idx_next   = last_idx;
                        a_next     = '0;
                        b_next     = YLW'(1);
                        o_next     = '0;
                        state_next = S_M_RD;
                    end
                    fcs_pkg::OP_QUERY:
                    begin
                        idx_next = '0;
                        if (!built_reg)
                        begin
                            res_status_next = fcs_pkg::ST_UNBUILT;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = lay_len_reg[0];
                            state_next = S_BS_RD;
                        end
                    end
                    default:
                    begin
                        res_status_next = cls_reg.status;
                        res_cat_next    = idx_reg;
                        state_next      = S_EMIT;
                    end
                endcase
            end
            S_A_USE:
            begin
                if ((clen != '0) && (key_reg < cat_rd_reg))
                begin
                    res_status_next = fcs_pkg::ST_ORDER;
                end
                else
                begin
                    cat_we                = 1'b1;
                    cat_len_next[idx_reg] = clen + 1'b1;
                    built_next            = 1'b0;
                    res_pos_next          = clen;
                end
                state_next = S_EMIT;
            end
            S_M_RD:
            begin
                state_next = S_M_USE;
            end
            S_M_USE:
            begin
                if ((a_reg < clen) || (b_reg < nlen))
                begin
                    lay_we = 1'b1;
                    o_next = o_reg + 1'b1;
                    if (take_cat)
                    begin
                        a_next = a_reg + 1'b1;
                    end
                    else
                    begin
                        b_next = b_reg + YLW'(2);
                    end
                    state_next = S_M_RD;
                end
                else
                begin
                    lay_len_next[idx_reg] = o_reg;
                    e_next     = '0;
                    p_next     = '0;
                    q_next     = '0;
                    state_next = S_P_RD;
                end
            end
            S_P_RD:
            begin
                if (e_reg == o_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        built_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        a_next     = '0;
                        b_next     = YLW'(1);
                        o_next     = '0;
                        state_next = S_M_RD;
                    end
                end
                else
                begin
                    state_next = S_P_USE;
                end
            end
            S_P_USE:
            begin
                // two-pointer lower bounds, both monotone over the sorted layer
                if ((p_reg < clen) && (cat_rd_reg < lay_a_rd_reg))
                begin
                    p_next = p_reg + 1'b1;
                end
                else if ((q_reg < nlen) && (lay_b_rd_reg < lay_a_rd_reg))
                begin
                    q_next = q_reg + 1'b1;
                end
                else
                begin
                    pos_we = 1'b1;
                    e_next = e_reg + 1'b1;
                end
                state_next = S_P_RD;
            end
            S_BS_RD:
            begin
                if (lo_reg >= hi_reg)
                begin
                    pos_next   = lo_reg;
                    state_next = S_WD_RD;
                end
                else
                begin
                    state_next = S_BS_USE;
                end
            end
            S_BS_USE:
            begin
                if (lay_a_rd_reg < key_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_BS_RD;
            end
            S_WD_RD:
            begin
                state_next = (pos_reg != '0) ? S_WD_USE : S_WU_RD;
            end
            S_WD_USE:
            begin
                if (lay_a_rd_reg >= key_reg)
                begin
                    pos_next   = pos_m1;
                    state_next = S_WD_RD;
                end
                else
                begin
                    state_next = S_WU_RD;
                end
            end
            S_WU_RD:
            begin
                state_next = (pos_reg < lcur) ? S_WU_USE : S_C_RD;
            end
            S_WU_USE:
            begin
                if (lay_a_rd_reg < key_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_WU_RD;
                end
                else
                begin
                    state_next = S_C_RD;
                end
            end
            S_C_RD:
            begin
                if (pos_reg == lcur)
                begin
                    cp_next    = clen;
                    state_next = S_F_RD;
                end
                else
                begin
                    state_next = S_C_USE;
                end
            end
            S_C_USE:
            begin
                cp_next     = pos_rd_reg[PMW-1:YLW];
                bridge_next = pos_rd_reg[YLW-1:0];
                state_next  = S_F_RD;
            end
            S_F_RD:
            begin
                res_status_next = fcs_pkg::ST_OK;
                res_cat_next    = idx_reg;
                res_pos_next    = cp_reg;
                res_found_next  = 1'b0;
                res_last_next   = !has_next;
                state_next      = (cp_reg < clen) ? S_F_USE : S_EMIT;
            end
            S_F_USE:
            begin
                res_found_next = (cat_rd_reg == key_reg);
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (res_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // follow the bridge into the next layer
                        pos_next   = (pos_reg == lcur) ? lay_len_reg[idx_p1] : bridge_reg;
                        idx_next   = idx_p1;
                        state_next = S_WD_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            built_next = 1'b0;
        end

        out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCP; i++)
            begin
                cat_len_reg[i] <= '0;
                lay_len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NCP; i++)
            begin
                cat_len_reg[i] <= cat_len_next[i];
                lay_len_reg[i] <= lay_len_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg        <= cls_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        o_reg          <= o_next;
        e_reg          <= e_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pos_reg        <= pos_next;
        cp_reg         <= cp_next;
        bridge_reg     <= bridge_next;
        res_status_reg <= res_status_next;
        res_cat_reg    <= res_cat_next;
        res_pos_reg    <= res_pos_next;
        res_found_reg  <= res_found_next;
        res_last_reg   <= res_last_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_cat_reg    <= res_cat_reg;
            out_pos_reg    <= res_pos_reg;
            out_found_reg  <= res_found_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    // catalog store
    always_ff @(posedge clk)
    begin
        if (cat_we)
        begin
            cat_mem[cat_wa] <= key_reg;
        end
        cat_rd_reg <= cat_mem[cat_ra];
    end

    // layer values, two read ports
    always_ff @(posedge clk)
    begin
        if (lay_we)
        begin
            lay_mem[lay_wa] <= lay_wd;
        end
        lay_a_rd_reg <= lay_mem[lay_a_ra];
        lay_b_rd_reg <= lay_mem[lay_b_ra];
    end

    // catalog and bridge positions per layer entry
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pos_rd_reg <= pos_mem[pos_ra];
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_catalog = out_cat_reg;
    assign position       = out_pos_reg;
    assign found          = out_found_reg;
    assign last           = out_last_reg;

`ifndef SYNTHESIS
    a_built_from_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> ($past(state_reg) == S_P_RD))
        else $error("layers marked built outside of a build");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && out_stall) |=> (state_reg == S_EMIT))
        else $error("result dropped while output stalled");

    a_cat_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cat_len_reg[idx_reg] <= LW'(CATALOG_DEPTH)))
        else $error("catalog length beyond depth");

    a_layer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lay_we |-> (o_reg < YLW'(2 * CATALOG_DEPTH)))
        else $error("layer write beyond layer depth");
`endif

endmodule
